// ===== hw/rtl/risc_subset_execute_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the RISC subset execute unit
// Immediate and next-cycle implication checks, compiled out by NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef RISC_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define RISC_SUBSET_EXECUTE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RSX_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rsx: implication check failed");

`define RSX_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rsx: next-cycle check failed");

`else

`define RSX_ASSERT_IMP(name, clk, rst_n, pre, post)

`define RSX_ASSERT_NXT(name, clk, rst_n, pre, post)

`endif

`endif

// ===== hw/rtl/rsx_pkg.sv =====
// ---------------------------------------------------------------------------
// rsx_pkg
// Opcodes, channel payload types and fixed constants of the execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rsx_pkg;

  localparam int DATA_WORDS = 1024;
  localparam int DSTORE_AW  = $clog2(DATA_WORDS);
  localparam int REG_COUNT  = 32;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int PC_W       = 16;
  localparam int CYC_W      = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_ADDI = 4'd2,
    OP_SUBI = 4'd3,
    OP_OR   = 4'd4,
    OP_AND  = 4'd5,
    OP_SLL  = 4'd6,
    OP_SRL  = 4'd7,
    OP_LW   = 4'd8,
    OP_SW   = 4'd9,
    OP_LBU  = 4'd10,
    OP_SBU  = 4'd11,
    OP_J    = 4'd12,
    OP_BEQ  = 4'd13,
    OP_BNE  = 4'd14,
    OP_SLT  = 4'd15
  } op_t;

  // cycle accounting modes; the fourth code counts as single-cycle
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_MULTI  = 2'd1;
  localparam logic [1:0] MODE_PIPE   = 2'd2;

  // multi-cycle cost by instruction class
  localparam logic [2:0] CLS_BRANCH = 3'd3;
  localparam logic [2:0] CLS_OTHER  = 3'd4;
  localparam logic [2:0] CLS_LOAD   = 3'd5;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef struct packed {
    op_t                op;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg;
    logic [4:0]         second_reg;
    logic signed [15:0] immediate;
    logic [4:0]         shift_amount;
    logic [10:0]        target_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic [31:0]        cycle_total;
    logic               reg_written;
    logic [4:0]         written_reg;
    logic signed [31:0] written_value;
    logic               mem_written;
    logic [9:0]         mem_address;
    logic               branch_taken;
  } out_item_t;

  typedef struct packed {
    logic [1:0] datapath_mode;
  } cfg_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsx_chan_if.sv =====
// ---------------------------------------------------------------------------
// rsx_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface rsx_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rsx_ram.sv =====
// ---------------------------------------------------------------------------
// rsx_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module rsx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/risc_subset_execute_unit.sv =====
// out_ch.valid rises once a transferred instruction reaches stage 2. Throughput:
// one instruction per cycle unless out_ch.ready stalls stage 2 or the reset clear
// runs; register reads and execute share stage 1, the data store read is registered
// into stage 2, and dependent items are forwarded. Reset: clears pc, cycle count,
// mode and register-file valid bits at once, then zeroes all 1024 data store words,
// one word per cycle, while in_ch.ready stays low (configuration writes are still taken).
// ---------------------------------------------------------------------------
// risc_subset_execute_unit
// Executes one decoded instruction per transfer on a 32-entry register file
// and a word-addressed data store, tracking pc and a simulated cycle count.
// ---------------------------------------------------------------------------
`default_nettype none

`include "risc_subset_execute_unit_assert.svh"

module risc_subset_execute_unit
  import rsx_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  rsx_chan_if.sink   in_ch,
  rsx_chan_if.source out_ch,
  rsx_chan_if.sink   cfg_ch
);

  typedef logic [WORD_BITS-1:0] word_t;

  // ---------------- control ----------------
  logic in_fire, out_fire, s1_adv;
  logic clear_busy_r;
  logic [DSTORE_AW-1:0] clr_addr_r;
  logic [1:0] mode_r;

  // ---------------- stage 1: operand fetch and execute ----------------
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [REG_AW-1:0] s1_rd_r, s1_ia_r, s1_ib_r;
  logic signed [15:0] s1_imm_r;
  logic [4:0]        s1_sh_r;
  logic [10:0]       s1_tgt_r;

  // ---------------- stage 2: result ----------------
  logic                 s2_valid_r;
  logic                 s2_rw_r, s2_mw_r, s2_br_r, s2_ld_r, s2_ldb_r, s2_byp_r;
  logic [REG_AW-1:0]    s2_rd_r;
  word_t                s2_val_r, s2_bypv_r;
  logic [DSTORE_AW-1:0] s2_addr_r;
  logic [PC_W-1:0]      s2_pc_r;
  logic [CYC_W-1:0]     s2_cyc_r;

  // last register write, for reads issued at the same edge
  logic              w_valid_r;
  logic [REG_AW-1:0] w_idx_r;
  word_t             w_val_r;
  logic [REG_COUNT-1:0] rf_valid_r;

  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CYC_W-1:0] cyc_r, cyc_nxt;

  word_t rfa_q, rfb_q, dm_q;
  word_t opa, opb, imm_ext, addr_sum, val;
  word_t ld_raw, ld_val, wb_val;
  logic  rw, mw, br, is_ld, ld_byte, mem_op, ld_byp, uses_d;
  logic [2:0] cls;
  logic [DSTORE_AW-1:0] addr;
  logic [REG_AW-1:0] in_ib;
  logic rf_we, dm_we;
  logic [DSTORE_AW-1:0] dm_waddr;
  word_t dm_wdata;

  // ---------------- handshakes ----------------
  assign s1_adv       = s1_valid_r && (!s2_valid_r || out_ch.ready);
  assign in_ch.ready  = !clear_busy_r && (!s1_valid_r || s1_adv);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = s2_valid_r;
  assign out_fire     = s2_valid_r && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // store and conditional-branch ops read the dest_reg operand on the second port
  assign uses_d = (in_ch.data.op == OP_SW) || (in_ch.data.op == OP_SBU) ||
                  (in_ch.data.op == OP_BEQ) || (in_ch.data.op == OP_BNE);
  assign in_ib  = uses_d ? in_ch.data.dest_reg : in_ch.data.second_reg;

  // ---------------- register file: two copies, one read port each ----------------
  assign rf_we = out_fire && s2_rw_r;

  rsx_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_rd_r),
    .wdata (wb_val),
    .re    (in_fire),
    .raddr (in_ch.data.src_reg),
    .rdata (rfa_q)
  );

  rsx_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_rd_r),
    .wdata (wb_val),
    .re    (in_fire),
    .raddr (in_ib),
    .rdata (rfb_q)
  );

  // ---------------- data store ----------------
  assign dm_we    = clear_busy_r || (out_fire && s2_mw_r);
  assign dm_waddr = clear_busy_r ? clr_addr_r : s2_addr_r;
  assign dm_wdata = clear_busy_r ? '0 : s2_val_r;

  rsx_ram #(.WIDTH(WORD_BITS), .DEPTH(DATA_WORDS)) u_dstore (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (s1_adv),
    .raddr (addr),
    .rdata (dm_q)
  );

  // ---------------- write-back value ----------------
  always_comb begin
    ld_raw = s2_byp_r ? s2_bypv_r : dm_q;
    ld_val = s2_ldb_r ? (ld_raw & WORD_BITS'(BYTE_MASK)) : ld_raw;
    wb_val = s2_ld_r ? ld_val : s2_val_r;
  end

  // ---------------- operand forwarding ----------------
  always_comb begin
    priority if (s2_valid_r && s2_rw_r && (s2_rd_r == s1_ia_r)) begin
      opa = wb_val;
    end else if (w_valid_r && (w_idx_r == s1_ia_r)) begin
      opa = w_val_r;
    end else if (rf_valid_r[s1_ia_r]) begin
      opa = rfa_q;
    end else begin
      opa = '0;
    end

    priority if (s2_valid_r && s2_rw_r && (s2_rd_r == s1_ib_r)) begin
      opb = wb_val;
    end else if (w_valid_r && (w_idx_r == s1_ib_r)) begin
      opb = w_val_r;
    end else if (rf_valid_r[s1_ib_r]) begin
      opb = rfb_q;
    end else begin
      opb = '0;
    end
  end

  // ---------------- execute ----------------
  assign imm_ext  = WORD_BITS'(s1_imm_r);
  assign addr_sum = opa + imm_ext;
  assign addr     = DSTORE_AW'(addr_sum);

  always_comb begin
    val     = '0;
    rw      = 1'b0;
    mw      = 1'b0;
    br      = 1'b0;
    is_ld   = 1'b0;
    ld_byte = 1'b0;
    mem_op  = 1'b0;
    cls     = CLS_OTHER;
    unique case (s1_op_r)
      OP_ADD:  begin val = opa + opb;       rw = 1'b1; end
      OP_SUB:  begin val = opa - opb;       rw = 1'b1; end
      OP_ADDI: begin val = opa + imm_ext;   rw = 1'b1; end
      OP_SUBI: begin val = opa - imm_ext;   rw = 1'b1; end
      OP_OR:   begin val = opa | opb;       rw = 1'b1; end
      OP_AND:  begin val = opa & opb;       rw = 1'b1; end
      OP_SLL:  begin val = opa << s1_sh_r;  rw = 1'b1; end
      OP_SRL:  begin val = opa >> s1_sh_r;  rw = 1'b1; end
      OP_LW: begin
        rw = 1'b1; is_ld = 1'b1; mem_op = 1'b1; cls = CLS_LOAD;
      end
      OP_SW: begin
        val = opb; mw = 1'b1; mem_op = 1'b1;
      end
      OP_LBU: begin
        rw = 1'b1; is_ld = 1'b1; ld_byte = 1'b1; mem_op = 1'b1; cls = CLS_LOAD;
      end
      OP_SBU: begin
        val = opb & WORD_BITS'(BYTE_MASK); mw = 1'b1; mem_op = 1'b1;
      end
      OP_J:   begin br = 1'b1;         cls = CLS_BRANCH; end
      OP_BEQ: begin br = (opb == opa); cls = CLS_BRANCH; end
      OP_BNE: begin br = (opb != opa); cls = CLS_BRANCH; end
      OP_SLT: begin
        val = WORD_BITS'($signed(opa) < $signed(opb));
        rw  = 1'b1;
      end
    endcase
  end

  // a load right behind a store to the same word reads the store data
  assign ld_byp = s2_valid_r && s2_mw_r && (s2_addr_r == addr);

  // ---------------- pc and cycle accounting ----------------
  always_comb begin
    pc_nxt = br ? PC_W'({s1_tgt_r, 2'b00}) : pc_r + PC_W'(4);
    unique case (mode_r)
      MODE_MULTI: cyc_nxt = cyc_r + CYC_W'(cls);
      MODE_PIPE:  cyc_nxt = (cyc_r == '0) ? CYC_W'(cls) : cyc_r + CYC_W'(1);
      default:    cyc_nxt = cyc_r + CYC_W'(1);
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clr_addr_r   <= '0;
      mode_r       <= MODE_SINGLE;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      w_valid_r    <= 1'b0;
      rf_valid_r   <= '0;
      pc_r         <= '0;
      cyc_r        <= '0;
    end else begin
      if (clear_busy_r) begin
        clr_addr_r <= clr_addr_r + DSTORE_AW'(1);
        if (clr_addr_r == DSTORE_AW'(DATA_WORDS - 1)) begin
          clear_busy_r <= 1'b0;
        end
      end
      if (cfg_ch.valid) begin
        mode_r <= cfg_ch.data.datapath_mode;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
        pc_r       <= pc_nxt;
        cyc_r      <= cyc_nxt;
      end else if (out_ch.ready) begin
        s2_valid_r <= 1'b0;
      end
      if (rf_we) begin
        w_valid_r           <= 1'b1;
        rf_valid_r[s2_rd_r] <= 1'b1;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_ch.data.op;
      s1_rd_r  <= in_ch.data.dest_reg;
      s1_ia_r  <= in_ch.data.src_reg;
      s1_ib_r  <= in_ib;
      s1_imm_r <= in_ch.data.immediate;
      s1_sh_r  <= in_ch.data.shift_amount;
      s1_tgt_r <= in_ch.data.target_index;
    end
    if (s1_adv) begin
      s2_rw_r   <= rw;
      s2_mw_r   <= mw;
      s2_br_r   <= br;
      s2_ld_r   <= is_ld;
      s2_ldb_r  <= ld_byte;
      s2_byp_r  <= ld_byp;
      s2_bypv_r <= s2_val_r;
      s2_rd_r   <= rw ? s1_rd_r : '0;
      s2_val_r  <= val;
      s2_addr_r <= mem_op ? addr : '0;
      s2_pc_r   <= pc_nxt;
      s2_cyc_r  <= cyc_nxt;
    end
    if (rf_we) begin
      w_idx_r <= s2_rd_r;
      w_val_r <= wb_val;
    end
  end

  // ---------------- result channel ----------------
  assign out_ch.data.next_pc       = s2_pc_r;
  assign out_ch.data.cycle_total   = s2_cyc_r;
  assign out_ch.data.reg_written   = s2_rw_r;
  assign out_ch.data.written_reg   = s2_rd_r;
  assign out_ch.data.written_value = 32'(wb_val);
  assign out_ch.data.mem_written   = s2_mw_r;
  assign out_ch.data.mem_address   = s2_addr_r;
  assign out_ch.data.branch_taken  = s2_br_r;

  // ---------------- assertions ----------------
  `RSX_ASSERT_IMP(a_clear_empty, clk, rst_n, clear_busy_r, !s1_valid_r && !s2_valid_r)
  `RSX_ASSERT_IMP(a_no_overrun, clk, rst_n, in_fire && s1_valid_r, s1_adv)
  `RSX_ASSERT_NXT(a_pc_step, clk, rst_n, s1_adv && !br, pc_r == PC_W'($past(pc_r) + PC_W'(4)))
  `RSX_ASSERT_IMP(a_store_no_rw, clk, rst_n, s2_valid_r && s2_mw_r, !s2_rw_r && (s2_rd_r == '0))
  `RSX_ASSERT_NXT(a_rf_mark, clk, rst_n, rf_we, w_valid_r && rf_valid_r[$past(s2_rd_r)])

endmodule

`default_nettype wire
